// ===== rtl/core/ssm_pkg.sv =====
// Shared types and constants of the segmented sieve marker.
// Used by the controller, the datapath and the top level; no dependencies.
package ssm_pkg;

  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned PRIME_W  = 20;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned INDEX_W  = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_STRIKE = 1'b0,
    OP_READ   = 1'b1
  } opcode_e;

  typedef struct packed {
    logic init_write;
    logic load_item;
    logic strike;
    logic rd_issue;
    logic rearm;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic strike_done;
    logic is_read;
    logic slot_free;
  } status_t;

endpackage

// ===== rtl/core/ssm_ctrl.sv =====
// Sequencer of the segmented sieve marker: clearing pass, strike walk, read and rearm.
// Depends on ssm_pkg for the command and status structs.
module ssm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ssm_pkg::status_t status_i,
  output ssm_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_STRIKE = 6'b000100,
    S_RD     = 6'b001000,
    S_WB     = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.init_write = 1'b1;
        if (status_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = status_i.is_read ? S_RD : S_STRIKE;
        end
      end
      S_STRIKE: begin
        cmd_o.strike = 1'b1;
        if (status_i.strike_done) begin
          state_d = S_FIN;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_WB;
      end
      S_WB: begin
        cmd_o.rearm = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (status_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/core/ssm_dp.sv =====
// Datapath of the segmented sieve marker: segment bitmap, strike position walk,
// result and output registers. Depends on ssm_pkg; driven by ssm_ctrl commands.
module ssm_dp #(
  parameter int unsigned SEGMENT_BITS = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssm_pkg::cmd_t                  cmd_i,
  output ssm_pkg::status_t               status_o,
  input  logic [ssm_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [ssm_pkg::PRIME_W-1:0]    prime_i,
  input  logic [ssm_pkg::OFFSET_W-1:0]   start_offset_i,
  input  logic [ssm_pkg::INDEX_W-1:0]    bit_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ssm_pkg::OFFSET_W-1:0]   next_offset_o,
  output logic                           survivor_o
);

  localparam int unsigned AW    = $clog2(SEGMENT_BITS);
  localparam int unsigned SEG_W = $clog2(SEGMENT_BITS + 1);
  localparam int unsigned BASE_W =
      (SEG_W > ssm_pkg::OFFSET_W) ? SEG_W : ssm_pkg::OFFSET_W;
  localparam int unsigned POS_W = BASE_W + 1;
  localparam logic [POS_W-1:0] SEG  = POS_W'(SEGMENT_BITS);
  localparam logic [AW-1:0]    LAST = AW'(SEGMENT_BITS - 1);

  logic                            mem_q [SEGMENT_BITS];
  logic                            rdata_q;

  logic [AW-1:0]                   init_cnt_q;
  ssm_pkg::opcode_e                op_q;
  logic [POS_W-1:0]                pos_q, pos_d;
  logic [ssm_pkg::PRIME_W-1:0]     step_q;
  logic [ssm_pkg::INDEX_W-1:0]     idx_q;
  logic [ssm_pkg::OFFSET_W-1:0]    res_off_q, res_off_d;
  logic                            res_surv_q, res_surv_d;
  logic                            out_valid_q, out_valid_d;
  logic [ssm_pkg::OFFSET_W-1:0]    out_off_q;
  logic                            out_surv_q;

  logic                            pos_in_seg;
  logic                            step_zero;
  logic                            idx_in_seg;
  logic [AW-1:0]                   idx_addr;
  logic                            we;
  logic [AW-1:0]                   waddr;
  logic                            wdata;

  assign pos_in_seg = (pos_q < SEG);
  assign step_zero  = (step_q == '0);
  assign idx_in_seg = (POS_W'(idx_q) < SEG);
  assign idx_addr   = AW'(idx_q);

  assign status_o.init_last   = (init_cnt_q == LAST);
  assign status_o.strike_done = !pos_in_seg || step_zero;
  assign status_o.is_read     = (ssm_pkg::opcode_e'(opcode_i) == ssm_pkg::OP_READ);
  assign status_o.slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    we    = 1'b0;
    waddr = idx_addr;
    wdata = 1'b1;
    if (cmd_i.init_write) begin
      we    = 1'b1;
      waddr = init_cnt_q;
    end else if (cmd_i.strike && pos_in_seg) begin
      we    = 1'b1;
      waddr = AW'(pos_q);
      wdata = 1'b0;
    end else if (cmd_i.rearm && idx_in_seg) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem_q[idx_addr];
    end
  end

  always_comb begin
    pos_d      = pos_q;
    res_off_d  = res_off_q;
    res_surv_d = res_surv_q;
    if (cmd_i.load_item) begin
      pos_d = POS_W'(start_offset_i);
    end else if (cmd_i.strike) begin
      if (!pos_in_seg) begin
        res_off_d  = ssm_pkg::OFFSET_W'(pos_q - SEG);
        res_surv_d = 1'b0;
      end else if (step_zero) begin
        res_off_d  = '0;
        res_surv_d = 1'b0;
      end else begin
        pos_d = pos_q + POS_W'(step_q);
      end
    end else if (cmd_i.rearm) begin
      res_off_d  = '0;
      res_surv_d = idx_in_seg && rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= ssm_pkg::opcode_e'(opcode_i);
      step_q <= prime_i;
      idx_q  <= bit_index_i;
    end
    pos_q      <= pos_d;
    res_off_q  <= res_off_d;
    res_surv_q <= res_surv_d;
    if (cmd_i.out_load) begin
      out_off_q  <= (op_q == ssm_pkg::OP_READ) ? '0 : res_off_q;
      out_surv_q <= (op_q == ssm_pkg::OP_READ) ? res_surv_q : 1'b0;
    end
  end

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init_write) begin
        init_cnt_q <= init_cnt_q + AW'(1);
      end
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_offset_o = out_off_q;
  assign survivor_o    = out_surv_q;

endmodule

// ===== rtl/core/segmented_sieve_marker_unit.sv =====
// Segmented sieve marker: one SEGMENT_BITS-position bitmap with strike and read items.
// Top level; instantiates ssm_ctrl and ssm_dp, uses ssm_pkg for shared types.
//
// After reset the block runs a clearing pass that sets every bitmap position,
// one position per cycle; in_ready_o stays low until it ends. Items are then
// taken one at a time. A read item goes through one registered bitmap read,
// one rearm write and one result load before its result is valid. A strike
// item clears one position per cycle through the single bitmap write port;
// the number of positions cleared is ceil((SEGMENT_BITS - start_offset) /
// prime) when the start lies inside the segment, and 0 otherwise. A zero
// prime with the start inside the segment clears its one position in the
// cycle that ends the walk. The next item is accepted the cycle after a
// result is loaded, even while that result still waits in the output
// register.
module segmented_sieve_marker_unit #(
  parameter int unsigned SEGMENT_BITS = 65536
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ssm_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [ssm_pkg::PRIME_W-1:0]  prime_i,
  input  logic [ssm_pkg::OFFSET_W-1:0] start_offset_i,
  input  logic [ssm_pkg::INDEX_W-1:0]  bit_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ssm_pkg::OFFSET_W-1:0] next_offset_o,
  output logic                         survivor_o
);

  ssm_pkg::cmd_t    cmd;
  ssm_pkg::status_t status;

  ssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssm_dp #(
    .SEGMENT_BITS (SEGMENT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .opcode_i       (opcode_i),
    .prime_i        (prime_i),
    .start_offset_i (start_offset_i),
    .bit_index_i    (bit_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_offset_o  (next_offset_o),
    .survivor_o     (survivor_o)
  );

endmodule

// ===== rtl/core/ssm_checker.sv =====
// Port-level checks of the segmented sieve marker and their bind to the top level.
// Depends on ssm_pkg for field widths and opcodes.
module ssm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [ssm_pkg::OPCODE_W-1:0] opcode_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [ssm_pkg::OFFSET_W-1:0] next_offset_o,
  input logic                         survivor_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(next_offset_o) && $stable(survivor_o))
    else $error("output item changed while stalled");

  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !survivor_o || (next_offset_o == '0))
    else $error("output item carries both offset and survivor");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while one is in work");

  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == ssm_pkg::OP_READ) && !out_valid_o
      |-> ##4 out_valid_o && (next_offset_o == '0))
    else $error("read item result late or malformed");

endmodule

bind segmented_sieve_marker_unit ssm_checker u_ssm_checker (.*);

// ===== verif/segmented_sieve_marker_unit_tb.sv =====
// Testbench for segmented_sieve_marker_unit: directed and random strike and read items.
// A driver and a monitor check each result against an in-bench bitmap predictor.
// Depends on ssm_pkg and the segmented_sieve_marker_unit RTL.
module segmented_sieve_marker_unit_tb;

  localparam int unsigned SEG       = 65536;
  localparam longint      MAX_CYCLE = 3000000;
  localparam int          N_RANDOM  = 600;

  typedef struct packed {
    ssm_pkg::opcode_e             op;
    logic [ssm_pkg::PRIME_W-1:0]  prime;
    logic [ssm_pkg::OFFSET_W-1:0] start;
    logic [ssm_pkg::INDEX_W-1:0]  idx;
  } sieve_item_t;

  typedef struct packed {
    logic [ssm_pkg::OFFSET_W-1:0] next_offset;
    logic                         survivor;
  } sieve_res_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic [ssm_pkg::OPCODE_W-1:0] opcode_i       = '0;
  logic [ssm_pkg::PRIME_W-1:0]  prime_i        = '0;
  logic [ssm_pkg::OFFSET_W-1:0] start_offset_i = '0;
  logic [ssm_pkg::INDEX_W-1:0]  bit_index_i    = '0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic [ssm_pkg::OFFSET_W-1:0] next_offset_o;
  logic                         survivor_o;

  sieve_item_t item_q[$];
  sieve_res_t  sieve_res_q[$];
  bit          seg_map [0:SEG-1];
  int          n_items     = 0;
  int          items_taken = 0;
  int          n_fail      = 0;
  int          burst_left  = 1;
  int          gap_left    = 0;
  int          stall_mode  = 0;
  int          mode_left   = 0;
  longint      cycle_cnt   = 0;

  segmented_sieve_marker_unit #(
    .SEGMENT_BITS(SEG)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .prime_i       (prime_i),
    .start_offset_i(start_offset_i),
    .bit_index_i   (bit_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .next_offset_o (next_offset_o),
    .survivor_o    (survivor_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void sieve_apply(sieve_item_t it);
    sieve_res_t      r;
    longint unsigned pos;
    r   = '0;
    pos = it.start;
    if (it.op == ssm_pkg::OP_STRIKE) begin
      if (pos >= SEG) begin
        r.next_offset = ssm_pkg::OFFSET_W'(pos - SEG);
      end else if (it.prime == '0) begin
        seg_map[pos] = 1'b0;
      end else begin
        while (pos < SEG) begin
          seg_map[pos] = 1'b0;
          pos += it.prime;
        end
        r.next_offset = ssm_pkg::OFFSET_W'(pos - SEG);
      end
    end else if (it.idx < SEG) begin
      r.survivor       = seg_map[it.idx];
      seg_map[it.idx]  = 1'b1;
    end
    sieve_res_q.push_back(r);
  endfunction

  task automatic add_strike(logic [ssm_pkg::PRIME_W-1:0] p, logic [ssm_pkg::OFFSET_W-1:0] s);
    sieve_item_t it;
    it.op    = ssm_pkg::OP_STRIKE;
    it.prime = p;
    it.start = s;
    it.idx   = ssm_pkg::INDEX_W'($urandom);
    item_q.push_back(it);
    n_items++;
  endtask

  task automatic add_read(logic [ssm_pkg::INDEX_W-1:0] idx);
    sieve_item_t it;
    it.op    = ssm_pkg::OP_READ;
    it.prime = ssm_pkg::PRIME_W'($urandom);
    it.start = ssm_pkg::OFFSET_W'($urandom);
    it.idx   = idx;
    item_q.push_back(it);
    n_items++;
  endtask

  // driver: bursts of items with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    sieve_item_t cur;
    sieve_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cur.op    = ssm_pkg::opcode_e'(opcode_i);
        cur.prime = prime_i;
        cur.start = start_offset_i;
        cur.idx   = bit_index_i;
        sieve_apply(cur);
        items_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (item_q.size() > 0) begin
          nxt = item_q.pop_front();
          opcode_i       <= nxt.op;
          prime_i        <= nxt.prime;
          start_offset_i <= nxt.start;
          bit_index_i    <= nxt.idx;
          in_valid_i     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: stretches of always ready, random, or mostly stalled
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(8, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor
  always @(posedge clk_i) begin
    sieve_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sieve_res_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual next_offset %0h survivor %0b",
                 $time, next_offset_o, survivor_o);
        n_fail++;
      end else begin
        exp_r = sieve_res_q.pop_front();
        if (next_offset_o !== exp_r.next_offset) begin
          $display("%0t next_offset mismatch: expected %0h actual %0h",
                   $time, exp_r.next_offset, next_offset_o);
          n_fail++;
        end
        if (survivor_o !== exp_r.survivor) begin
          $display("%0t survivor mismatch: expected %0b actual %0b",
                   $time, exp_r.survivor, survivor_o);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("%0t timeout: expected %0d results pending", $time, sieve_res_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int          kind;
    int          n_rand;
    int          j;
    logic [19:0] p;
    logic [19:0] s;
    for (int i = 0; i < SEG; i++) seg_map[i] = 1'b1;

    // directed
    add_read(16'h0000);
    add_read(16'hFFFF);
    add_strike(20'd0, 20'd5);
    add_read(16'd5);
    add_read(16'd5);
    add_strike(20'd0, 20'hFFFFF);
    add_strike(20'd0, 20'd65536);
    add_strike(20'hFFFFF, 20'd0);
    add_read(16'd0);
    add_strike(20'hFFFFF, 20'hFFFFF);
    add_strike(20'd7, 20'd65536);
    add_strike(20'd1, 20'd65535);
    add_read(16'hFFFF);
    add_strike(20'd65536, 20'd0);
    add_strike(20'd1, 20'd65000);
    add_read(16'd65000);
    add_read(16'd65535);
    add_strike(20'd2, 20'd1);
    add_read(16'd1);
    add_read(16'd2);
    add_read(16'd65535);
    add_strike(20'd3, 20'd65534);

    // random
    n_rand = 0;
    while (n_rand < N_RANDOM) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // strike followed by reads of its marks and of a random position
        p = 20'($urandom_range(4096, 20'hFFFFF));
        s = 20'($urandom_range(0, SEG - 1));
        add_strike(p, s);
        add_read(s[15:0]);
        n_rand += 2;
        if (s + p < SEG) begin
          add_read(16'(s + p));
          n_rand++;
        end
        if ($urandom_range(0, 1) == 1) begin
          add_read(s[15:0]);
          n_rand++;
        end
        add_read(ssm_pkg::INDEX_W'($urandom));
        n_rand++;
      end else if (kind < 68) begin
        p = 20'($urandom_range(256, 4095));
        s = 20'($urandom_range(0, SEG - 1));
        add_strike(p, s);
        j = $urandom_range(0, 3);
        add_read(16'(s + j * p < SEG ? s + j * p : s));
        n_rand += 2;
      end else if (kind < 82) begin
        p = 20'($urandom);
        s = 20'($urandom);
        if (s < SEG && p < 256) s = 20'(SEG - 1 - (s & 20'hFF));
        add_strike(p, s);
        n_rand++;
      end else if (kind < 94) begin
        add_read(ssm_pkg::INDEX_W'($urandom));
        n_rand++;
      end else begin
        s = ($urandom_range(0, 1) == 1) ? 20'($urandom) : 20'($urandom_range(0, SEG - 1));
        add_strike(20'd0, s);
        add_read(s[15:0]);
        n_rand += 2;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken < n_items || sieve_res_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
